[hdl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

	// Table geometry.
	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int POS_WIDTH   = $clog2(DEPTH);
	localparam int CNT_WIDTH   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOOKUP   = 2'd0,
		OP_INSERT   = 2'd1,
		OP_DELETE   = 2'd2,
		OP_RESERVED = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_DUPLICATE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_UPDATE
	} state_t;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic                        compare;
		logic                        insert;
		logic                        remove;
		logic signed [KEY_WIDTH-1:0] key;
		logic [VALUE_WIDTH-1:0]      value;
	} cell_ctrl_t;

endpackage

[hdl/sorted_key_table_core.sv]
`timescale 1ns / 1ps

// Sorted key table. Holds up to 16 unique signed 32-bit keys in ascending
// order, each with a 32-bit value, in a row of cells that each own one slot.
// An item asks for a lookup, an insert or a delete and always yields exactly
// one result with a status, the found value, the sorted position and the entry
// count after the operation. The item is captured at its input transfer. In
// the next cycle every cell compares its key with the item's key in parallel.
// In the update step after that, the position is counted from the compare
// flags and the row shifts its entries up or down by one slot in a single
// step, while the result is loaded into the output register. The block then
// returns to idle and takes the next item only there, never before it is
// through with the last one. While a result waits in the output register,
// one more item can be taken and compared; it then holds in its update
// step, and the input side stays stalled, until the output register frees.
// The capacity register may lower the number of entries allowed below 16;
// the user must write it only while the table is idle; the block itself
// does not enforce this.
module sorted_key_table_core (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             opcode,
	input  logic signed [skt_pkg::KEY_WIDTH-1:0]   key,
	input  logic [skt_pkg::VALUE_WIDTH-1:0]        value,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             status,
	output logic [skt_pkg::VALUE_WIDTH-1:0]        found_value,
	output logic [skt_pkg::POS_WIDTH-1:0]          position,
	output logic [skt_pkg::CNT_WIDTH-1:0]          entry_count,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [skt_pkg::CNT_WIDTH-1:0]          capacity_limit
);

	localparam int DEPTH = skt_pkg::DEPTH;
	localparam int CW    = skt_pkg::CNT_WIDTH;
	localparam int PW    = skt_pkg::POS_WIDTH;
	localparam int KW    = skt_pkg::KEY_WIDTH;
	localparam int VW    = skt_pkg::VALUE_WIDTH;

	skt_pkg::state_t  state_q, state_next;

	// Captured item.
	skt_pkg::opcode_t       op_q;
	logic signed [KW-1:0]   key_q;
	logic [VW-1:0]          value_q;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          cap_q;

	// Output register.
	logic                   out_valid_q;
	skt_pkg::status_t       status_q;
	logic [VW-1:0]          found_q;
	logic [PW-1:0]          pos_q;
	logic [CW-1:0]          cnt_out_q;

	// Cell row.
	skt_pkg::cell_ctrl_t    ctrl;
	logic [DEPTH-1:0]       lt_vec;
	logic [DEPTH-1:0]       eq_vec;
	logic [DEPTH-1:0]       occupied;
	logic signed [KW-1:0]   cell_key   [DEPTH];
	logic [VW-1:0]          cell_value [DEPTH];

	// Result of the update step.
	logic                   out_free;
	logic                   fire;
	logic [CW-1:0]          idx;
	logic                   hit;
	logic [CW-1:0]          limit;
	logic [VW-1:0]          hit_value;
	skt_pkg::status_t       res_status;
	logic [VW-1:0]          res_value;
	logic [PW-1:0]          res_pos;
	logic [CW-1:0]          res_count;
	logic                   ins_go;
	logic                   del_go;
	logic                   in_take;

	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = (state_q == skt_pkg::S_UPDATE) && out_free;

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			skt_pkg::S_IDLE: begin
				if (in_valid) begin
					state_next = skt_pkg::S_COMPARE;
				end
			end
			skt_pkg::S_COMPARE: begin
				state_next = skt_pkg::S_UPDATE;
			end
			skt_pkg::S_UPDATE: begin
				if (out_free) begin
					state_next = skt_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = skt_pkg::S_IDLE;
			end
		endcase
	end

	// State outputs: the input side is open only while idle, and the cells
	// are told what to do from the captured item.
	always_comb begin
		in_stall     = 1'b1;
		ctrl.compare = 1'b0;
		ctrl.insert  = 1'b0;
		ctrl.remove  = 1'b0;
		ctrl.key     = key_q;
		ctrl.value   = value_q;
		unique case (state_q)
			skt_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			skt_pkg::S_COMPARE: begin
				ctrl.compare = 1'b1;
			end
			skt_pkg::S_UPDATE: begin
				ctrl.insert = out_free && ins_go;
				ctrl.remove = out_free && del_go;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// The captured item is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q    <= skt_pkg::opcode_t'(opcode);
			key_q   <= key;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= capacity_limit;
		end
	end

	// The row of cells. A slot is occupied while its index is below the
	// entry count; slots at or above the count are never compared as hits.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                 left_lt;
		logic signed [KW-1:0] left_key;
		logic [VW-1:0]        left_value;
		logic signed [KW-1:0] right_key;
		logic [VW-1:0]        right_value;

		assign occupied[g] = CW'(g) < count_q;

		if (g == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_key   = key_q;
			assign left_value = value_q;
		end else begin : g_inner_left
			assign left_lt    = lt_vec[g-1];
			assign left_key   = cell_key[g-1];
			assign left_value = cell_value[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_key   = cell_key[g];
			assign right_value = cell_value[g];
		end else begin : g_inner_right
			assign right_key   = cell_key[g+1];
			assign right_value = cell_value[g+1];
		end

		skt_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occupied[g]),
			.left_lt     (left_lt),
			.left_key    (left_key),
			.left_value  (left_value),
			.right_key   (right_key),
			.right_value (right_value),
			.lt          (lt_vec[g]),
			.eq          (eq_vec[g]),
			.key         (cell_key[g]),
			.value       (cell_value[g])
		);
	end

	// Keys are unique, so at most one cell flags a hit and its value can be
	// gathered with a plain OR across the row.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq_vec[i]) begin
				hit_value = hit_value | cell_value[i];
			end
		end
	end

	// The smaller-than flags form a run from slot zero, so the insertion
	// point is simply how many of them are set.
	assign idx   = CW'($countones(lt_vec));
	assign hit   = |eq_vec;
	assign limit = (cap_q > CW'(DEPTH)) ? CW'(DEPTH) : cap_q;

	always_comb begin
		res_status = skt_pkg::ST_OK;
		res_value  = '0;
		res_pos    = '0;
		res_count  = count_q;
		ins_go     = 1'b0;
		del_go     = 1'b0;
		unique case (op_q)
			skt_pkg::OP_LOOKUP: begin
				if (hit) begin
					res_value = hit_value;
					res_pos   = idx[PW-1:0];
				end else begin
					res_status = skt_pkg::ST_NOT_FOUND;
				end
			end
			skt_pkg::OP_INSERT: begin
				// A full table is reported ahead of a duplicate key.
				priority if (count_q >= limit) begin
					res_status = skt_pkg::ST_FULL;
				end else if (hit) begin
					res_status = skt_pkg::ST_DUPLICATE;
				end else begin
					ins_go    = 1'b1;
					res_pos   = idx[PW-1:0];
					res_count = count_q + CW'(1);
				end
			end
			skt_pkg::OP_DELETE: begin
				if (hit) begin
					del_go    = 1'b1;
					res_pos   = idx[PW-1:0];
					res_count = count_q - CW'(1);
				end else begin
					res_status = skt_pkg::ST_NOT_FOUND;
				end
			end
			skt_pkg::OP_RESERVED: begin
				res_status = skt_pkg::ST_OK;
			end
			default: begin
				res_status = skt_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= res_count;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= res_status;
			found_q   <= res_value;
			pos_q     <= res_pos;
			cnt_out_q <= res_count;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign position    = pos_q;
	assign entry_count = cnt_out_q;

`ifndef SYNTHESIS
	// The row stays sorted: smaller-than flags form a run from slot zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skt_pkg::S_UPDATE |-> ((lt_vec + DEPTH'(1)) & lt_vec) == '0)
		else $error("compare flags of the cell row are not a contiguous run");

	// Keys are unique, so no more than one cell may hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skt_pkg::S_UPDATE |-> $onehot0(eq_vec))
		else $error("more than one cell reports a key match");

	// A cell cannot be both smaller than and equal to the key.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skt_pkg::S_UPDATE |-> (lt_vec & eq_vec) == '0)
		else $error("cell reports both smaller and equal");

	// A successful insert grows the table by exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && ins_go |=> count_q == $past(count_q) + CW'(1))
		else $error("entry count did not follow an insert");

	// The entry count never exceeds the row length.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");
`endif

endmodule

[hdl/skt_cell.sv]
`timescale 1ns / 1ps

// One slot of the sorted row. It compares its key with the broadcast key and,
// on an insert or a delete, takes the entry of its left or right neighbor.
module skt_cell (
	input  logic                                 clk,
	input  skt_pkg::cell_ctrl_t                  ctrl,
	input  logic                                 occupied,
	input  logic                                 left_lt,
	input  logic signed [skt_pkg::KEY_WIDTH-1:0] left_key,
	input  logic [skt_pkg::VALUE_WIDTH-1:0]      left_value,
	input  logic signed [skt_pkg::KEY_WIDTH-1:0] right_key,
	input  logic [skt_pkg::VALUE_WIDTH-1:0]      right_value,
	output logic                                 lt,
	output logic                                 eq,
	output logic signed [skt_pkg::KEY_WIDTH-1:0] key,
	output logic [skt_pkg::VALUE_WIDTH-1:0]      value
);

	logic signed [skt_pkg::KEY_WIDTH-1:0] key_q;
	logic [skt_pkg::VALUE_WIDTH-1:0]      value_q;
	logic                                 lt_q;
	logic                                 eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			lt_q <= occupied && (key_q < ctrl.key);
			eq_q <= occupied && (key_q == ctrl.key);
		end
		// Slots holding smaller keys keep their entry; the first larger slot
		// takes the new entry and every slot above it takes its left neighbor.
		if (ctrl.insert && !lt_q) begin
			if (left_lt) begin
				key_q   <= ctrl.key;
				value_q <= ctrl.value;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end
		// The hit slot and everything above it take the right neighbor.
		if (ctrl.remove && !lt_q) begin
			key_q   <= right_key;
			value_q <= right_value;
		end
	end

	assign lt    = lt_q;
	assign eq    = eq_q;
	assign key   = key_q;
	assign value = value_q;

endmodule

[bench/sorted_key_table_checker.sv]
`timescale 1ns / 1ps

// Passive checker for the sorted key table. Keeps its own copy of the table,
// predicts one result per request transfer and compares the result transfers
// in order.
module sorted_key_table_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic [1:0]                             opcode,
	input  logic signed [skt_pkg::KEY_WIDTH-1:0]   key,
	input  logic [skt_pkg::VALUE_WIDTH-1:0]        value,

	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic [1:0]                             status,
	input  logic [skt_pkg::VALUE_WIDTH-1:0]        found_value,
	input  logic [skt_pkg::POS_WIDTH-1:0]          position,
	input  logic [skt_pkg::CNT_WIDTH-1:0]          entry_count,

	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [skt_pkg::CNT_WIDTH-1:0]          capacity_limit,

	output int                                     mismatch_count,
	output int                                     pending_count,
	output int                                     checked_count,
	output int                                     reject_count
);

	import skt_pkg::*;

	typedef struct packed {
		status_t                status;
		logic [VALUE_WIDTH-1:0] found_value;
		logic [POS_WIDTH-1:0]   position;
		logic [CNT_WIDTH-1:0]   entry_count;
	} table_result_t;

	logic signed [KEY_WIDTH-1:0] stored_keys   [DEPTH];
	logic [VALUE_WIDTH-1:0]      stored_values [DEPTH];
	int                          used_entries;
	logic [CNT_WIDTH-1:0]        capacity;
	table_result_t               awaited_results [$];
	table_result_t               want;

	// Applies one request to the local table and returns the result it should give.
	function automatic table_result_t apply_request(input opcode_t op,
			input logic signed [KEY_WIDTH-1:0] k, input logic [VALUE_WIDTH-1:0] v);
		table_result_t r;
		int            lo;
		int            hi;
		int            mid;
		int            i;
		int            limit;
		logic          hit;
		r = '0;
		limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
		lo = 0;
		hi = used_entries;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored_keys[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		hit = (lo < used_entries) && (stored_keys[lo] == k);
		case (op)
			OP_LOOKUP: begin
				if (hit) begin
					r.found_value = stored_values[lo];
					r.position = POS_WIDTH'(lo);
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			OP_INSERT: begin
				if (used_entries >= limit) begin
					r.status = ST_FULL;
				end else if (hit) begin
					r.status = ST_DUPLICATE;
				end else begin
					for (i = used_entries; i > lo; i--) begin
						stored_keys[i] = stored_keys[i - 1];
						stored_values[i] = stored_values[i - 1];
					end
					stored_keys[lo] = k;
					stored_values[lo] = v;
					used_entries++;
					r.position = POS_WIDTH'(lo);
				end
			end
			OP_DELETE: begin
				if (!hit) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (i = lo; i + 1 < used_entries; i++) begin
						stored_keys[i] = stored_keys[i + 1];
						stored_values[i] = stored_values[i + 1];
					end
					used_entries--;
					stored_keys[used_entries] = '0;
					stored_values[used_entries] = '0;
					r.position = POS_WIDTH'(lo);
				end
			end
			default: begin
			end
		endcase
		r.entry_count = CNT_WIDTH'(used_entries);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_entries = 0;
			capacity = CNT_WIDTH'(16);
			awaited_results.delete();
			mismatch_count = 0;
			pending_count = 0;
			checked_count = 0;
			reject_count = 0;
		end else begin
			// Retire the result first; a request taken on this edge cannot produce it.
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result transfer with nothing outstanding: status %0d value %h position %0d count %0d",
							$time, status, found_value, position, entry_count);
				end else begin
					want = awaited_results.pop_front();
					checked_count++;
					if (want.status == ST_FULL || want.status == ST_DUPLICATE)
						reject_count++;
					if (want.status != status || want.found_value != found_value ||
							want.position != position || want.entry_count != entry_count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: MISMATCH status %0d/%0d value %h/%h position %0d/%0d count %0d/%0d (expected/actual)",
								$time, want.status, status, want.found_value, found_value,
								want.position, position, want.entry_count, entry_count);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_request(opcode_t'(opcode), key, value));
			if (cfg_valid && cfg_ready)
				capacity = capacity_limit;
			pending_count = awaited_results.size();
		end
	end

endmodule

[bench/sorted_key_table_core_tb.sv]
`timescale 1ns / 1ps

// Top of the sorted key table bench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result and
// counts mismatches.
module sorted_key_table_core_tb;

	import skt_pkg::*;

	// A few extreme keys that every key pool starts with.
	localparam logic [KEY_WIDTH-1:0] KEY_MIN  = 32'h8000_0000;
	localparam logic [KEY_WIDTH-1:0] KEY_MAX  = 32'h7fff_ffff;
	localparam logic [KEY_WIDTH-1:0] KEY_NEG1 = 32'hffff_ffff;

	localparam int POOL_SIZE    = 20;
	localparam int SETTLE       = 8;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;

	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    opcode;
	logic signed [KEY_WIDTH-1:0]   key;
	logic [VALUE_WIDTH-1:0]        value;

	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    status;
	logic [VALUE_WIDTH-1:0]        found_value;
	logic [POS_WIDTH-1:0]          position;
	logic [CNT_WIDTH-1:0]          entry_count;

	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CNT_WIDTH-1:0]          capacity_limit;

	// The result side is stalled either by the per-result idling of the sink
	// or by the one long hold-off that backs the table up.
	logic sink_stall;
	logic hold_active;
	logic hold_start;
	assign out_stall = sink_stall | hold_active;

	int mismatch_count;
	int pending_count;
	int checked_count;
	int reject_count;

	int  cycle_count = 0;
	int  requests_sent = 0;
	int  capacity_writes = 0;
	bit  calm_mode;
	logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

	always #5 clk = ~clk;

	sorted_key_table_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_value    (found_value),
		.position       (position),
		.entry_count    (entry_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_limit (capacity_limit)
	);

	sorted_key_table_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_value    (found_value),
		.position       (position),
		.entry_count    (entry_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_limit (capacity_limit),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count),
		.reject_count   (reject_count)
	);

	// Watchdog. Reaching the cycle limit means the block has hung or lost a
	// result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result sink. Before each result transfer it draws a random stall, possibly
	// none, so the stall lands on every phase of the block's work. Every 64
	// results it may switch into a steady stretch in which it never stalls.
	initial begin
		int waits;
		int served;
		bit steady;
		sink_stall = 1'b0;
		served = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (served % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			waits = steady ? 0 : $urandom_range(0, 3);
			if (waits != 0) begin
				sink_stall <= 1'b1;
				repeat (waits) @(negedge clk);
			end
			sink_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			served++;
		end
	end

	// Long hold-off of the result side, counted here in its own process. The
	// sender keeps offering requests meanwhile, so the block fills up and must
	// stall its request side until the hold-off ends.
	initial begin
		hold_active = 1'b0;
		@(posedge hold_start);
		@(negedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_active <= 1'b0;
	end

	// Offers one request and returns at the falling edge after its transfer.
	// Valid is held high across back-to-back requests; only the payload moves.
	task automatic offer_item(input opcode_t op, input logic [KEY_WIDTH-1:0] k,
			input logic [VALUE_WIDTH-1:0] v);
		int gap;
		gap = calm_mode ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= op;
		key <= k;
		value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		@(negedge clk);
	endtask

	// Writes the capacity register. It is only written with the table idle:
	// every outstanding result has come back and the pipeline has had time
	// to settle.
	task automatic set_capacity(input logic [CNT_WIDTH-1:0] lim);
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		capacity_limit <= lim;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		capacity_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A fresh key pool for each phase: the four extreme keys, a few small keys
	// of both signs near zero, and the rest fully random. With more keys than
	// slots, inserts, hits, misses and duplicates all come up often.
	task automatic refill_pool();
		int i;
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = '0;
		key_pool[3] = KEY_NEG1;
		for (i = 4; i < POOL_SIZE; i++)
			key_pool[i] = (i < 10) ? $urandom_range(0, 40) - 20 : $urandom;
	endtask

	// One random request. Most keys come from the pool so that they hit the
	// table; the rest are random over the full 32-bit range and nearly always
	// miss. A small share uses the reserved opcode.
	task automatic offer_random(input int ins_pct, input int del_pct);
		int                   roll;
		opcode_t              op;
		logic [KEY_WIDTH-1:0] k;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			op = OP_RESERVED;
		else if (roll < 5 + ins_pct)
			op = OP_INSERT;
		else if (roll < 5 + ins_pct + del_pct)
			op = OP_DELETE;
		else
			op = OP_LOOKUP;
		if ($urandom_range(0, 99) < 85)
			k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			k = $urandom;
		offer_item(op, k, $urandom);
	endtask

	// One phase: a capacity setting, then random requests with a given mix.
	// The mix steers the fill level, so that some phases run the table full
	// and others drain it.
	task automatic run_phase(input logic [CNT_WIDTH-1:0] cap, input int n_items,
			input int ins_pct, input int del_pct, input bit calm, input bit with_hold);
		int i;
		set_capacity(cap);
		refill_pool();
		calm_mode = calm;
		for (i = 0; i < n_items; i++) begin
			if (with_hold && i == 40)
				hold_start <= 1'b1;
			offer_random(ins_pct, del_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LOOKUP;
		key = '0;
		value = '0;
		cfg_valid = 1'b0;
		capacity_limit = CNT_WIDTH'(16);
		hold_start = 1'b0;
		calm_mode = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset capacity of 16. An empty table answers
		// not-found to both lookup and delete.
		offer_item(OP_LOOKUP, 32'd5, 32'h0);
		offer_item(OP_DELETE, 32'd5, 32'h0);
		// Fill with the extreme keys in an order that forces shifts at both
		// ends and in the middle, and with the extreme values.
		offer_item(OP_INSERT, 32'd0, 32'h0000_0000);
		offer_item(OP_INSERT, KEY_MIN, 32'hffff_ffff);
		offer_item(OP_INSERT, KEY_MAX, 32'ha5a5_a5a5);
		offer_item(OP_INSERT, KEY_NEG1, 32'h5a5a_5a5a);
		offer_item(OP_INSERT, 32'd1, 32'h0000_0001);
		// A duplicate key is rejected and its value is not stored.
		offer_item(OP_INSERT, 32'd0, 32'h0000_0007);
		offer_item(OP_LOOKUP, KEY_MIN, 32'h0);
		offer_item(OP_LOOKUP, KEY_MAX, 32'h0);
		offer_item(OP_LOOKUP, KEY_NEG1, 32'h0);
		// A key that falls between two stored keys misses.
		offer_item(OP_LOOKUP, 32'd2, 32'h0);
		// The reserved opcode changes nothing and still answers.
		offer_item(OP_RESERVED, 32'd1, 32'hdead_beef);
		// Deletes in the middle, at the last slot and at the first slot.
		offer_item(OP_DELETE, 32'd0, 32'h0);
		offer_item(OP_DELETE, KEY_MAX, 32'h0);
		offer_item(OP_DELETE, KEY_MIN, 32'h0);
		offer_item(OP_LOOKUP, 32'd0, 32'h0);
		offer_item(OP_DELETE, 32'd0, 32'h0);
		offer_item(OP_INSERT, KEY_MAX, 32'h1234_5678);
		// Capacity lowered below the three stored entries: every entry stays,
		// and each insert is full, even one whose key is already present.
		set_capacity(CNT_WIDTH'(2));
		offer_item(OP_INSERT, 32'd1, 32'h0000_0099);
		offer_item(OP_INSERT, 32'd100, 32'h0000_0099);
		offer_item(OP_LOOKUP, 32'd1, 32'h0);

		// Random phases. A capacity of 31 acts as 16, 0 rejects every insert,
		// and 4 after a full table exercises capacity below the count again.
		run_phase(CNT_WIDTH'(16), 160, 40, 30, 1'b0, 1'b0);
		run_phase(CNT_WIDTH'(31), 160, 70, 10, 1'b0, 1'b0);
		run_phase(CNT_WIDTH'(4), 160, 30, 35, 1'b1, 1'b0);
		run_phase(CNT_WIDTH'(0), 120, 50, 30, 1'b0, 1'b0);
		run_phase(CNT_WIDTH'(1), 150, 45, 35, 1'b0, 1'b0);
		run_phase(CNT_WIDTH'(16), 200, 60, 20, 1'b0, 1'b1);
		run_phase(CNT_WIDTH'($urandom_range(0, 31)), 150, 50, 30, 1'b0, 1'b0);
		run_phase(CNT_WIDTH'(16), 200, 35, 45, 1'b1, 1'b0);
		run_phase(CNT_WIDTH'($urandom_range(0, 31)), 160, 50, 30, 1'b0, 1'b0);
		run_phase(CNT_WIDTH'(10), 160, 50, 40, 1'b0, 1'b0);

		// Let every outstanding result come back, then idle for DRAIN_CYCLES so
		// that any stray result from the block would show.
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Summary: %0d requests, %0d capacity writes, %0d results checked",
			requests_sent, capacity_writes, checked_count);
		$display("Summary: %0d inserts rejected, one %0d-cycle hold-off, %0d mismatches",
			reject_count, HOLD_CYCLES, mismatch_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
